[rtl/core/phnl_pkg.sv]
// ----------------------------------------------------------------------------
// Perfect hash name lookup package
// Shared types, codes and constants of the name lookup block.
// ----------------------------------------------------------------------------
package phnl_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned MaxKeyLenDef  = 64;

  localparam logic [31:0] FnvSeed = 32'h0100_0193;
  localparam logic [31:0] FnvMul  = 32'h0100_0193;

  localparam int unsigned NumW  = 11;  // width of the entry count register
  localparam int unsigned HashW = 32;

  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_DISP  = 2'd1,
    MODE_FINAL = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         table_index;
    logic signed [31:0] table_value;
    logic [7:0]         key_char;
    logic               key_last;
  } item_t;

  typedef struct packed {
    logic [9:0] file_index;
    logic       lookup_error;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOD,
    S_DISP_RD,
    S_DISP_CHK,
    S_KEY_RD,
    S_KEY_FOLD,
    S_FIN_RD,
    S_FIN_OUT
  } state_e;

  // One step of the running hash: multiply, then fold in the sign-extended byte.
  function automatic logic [31:0] fold_char(logic [31:0] h, logic [7:0] c);
    logic [31:0] ext;
    ext = {{24{c[7]}}, c};
    return (h * FnvMul) ^ ext;
  endfunction

endpackage

[rtl/core/perfect_hash_name_lookup.sv]
// ----------------------------------------------------------------------------
// Perfect hash name lookup
// Hash-and-displace minimal perfect hash lookup of a streamed key.
// ----------------------------------------------------------------------------
// Key characters and table writes are taken while idle and leave busy low,
// but a key's end character starts a lookup. A lookup holds busy through the
// bit-serial modulo (one quotient bit a cycle, shared by both hashes) and, on
// the rehash path, the walk over the buffered key. An overflowed key or a bad
// entry count ends in an error in S_CHECK, a negative displacement out of
// range in S_DISP_CHK. The one-cycle result strobe comes in the first idle
// cycle and the receiver cannot stall it. Reset clears the sequencer, key
// length and flags and seeds the hash; tables need writes.
module perfect_hash_name_lookup #(
  parameter int unsigned TABLE_DEPTH = phnl_pkg::TableDepthDef,
  parameter int unsigned MAX_KEY_LEN = phnl_pkg::MaxKeyLenDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  phnl_pkg::item_t             item_i,
  input  logic                        cfg_we_i,
  input  logic [phnl_pkg::NumW-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output phnl_pkg::result_t           result_o
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned KAW = $clog2(MAX_KEY_LEN);
  localparam int unsigned KLW = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned NW  = phnl_pkg::NumW;

  // Storage
  logic [31:0] disp_mem  [TABLE_DEPTH];
  logic [9:0]  final_mem [TABLE_DEPTH];
  logic [7:0]  key_mem   [MAX_KEY_LEN];
  logic [31:0] disp_rd_q;
  logic [9:0]  final_rd_q;
  logic [7:0]  key_rd_q;

  // Control and work registers
  phnl_pkg::state_e state_q, state_d;
  logic [NW-1:0]    num_q;
  logic [31:0]      hash_q, hash_d;
  logic [KLW-1:0]   len_q, len_d;
  logic [KLW-1:0]   kidx_q, kidx_d;
  logic             ovf_q, ovf_d;
  logic [NW-1:0]    rem_q, rem_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic [AW-1:0]    faddr_q, faddr_d;
  logic             done_q, done_d;
  phnl_pkg::result_t res_q, res_d;

  logic            accept;
  logic            is_key, is_end, is_wr_ok;
  logic [31:0]     tidx_ext, rem_ext, neg_j, mul_in, fold_out, seed_d;
  logic [7:0]      fold_c;
  logic [NW:0]     trial;
  logic [AW-1:0]   tidx_addr, disp_raddr;
  logic [KAW-1:0]  key_raddr;
  logic            bad_num;

  assign busy     = (state_q != phnl_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign is_key   = (item_i.mode == phnl_pkg::MODE_KEY);
  assign is_end   = is_key && ((item_i.key_char == 8'd0) || item_i.key_last);
  assign tidx_ext = 32'(item_i.table_index);
  assign tidx_addr = tidx_ext[AW-1:0];
  assign is_wr_ok = (tidx_ext < 32'(TABLE_DEPTH));
  assign rem_ext  = 32'(rem_q);
  assign disp_raddr = rem_ext[AW-1:0];
  assign neg_j    = ~disp_rd_q;
  assign seed_d   = (disp_rd_q == 32'd0) ? phnl_pkg::FnvSeed : disp_rd_q;
  assign bad_num  = (num_q == '0) || (32'(num_q) > 32'(TABLE_DEPTH));
  assign key_raddr = kidx_q[KAW-1:0];

  // The one multiplier: fed by the incoming character or the buffered one.
  assign mul_in   = hash_q;
  assign fold_c   = busy ? key_rd_q : item_i.key_char;
  assign fold_out = phnl_pkg::fold_char(mul_in, fold_c);

  // One restoring step of the modulo: shift in the next hash bit, subtract.
  assign trial = {rem_q, hash_q[31]};

  // Table and key memories
  always_ff @(posedge clk_i) begin
    if (accept && is_wr_ok && item_i.mode == phnl_pkg::MODE_DISP) begin
      disp_mem[tidx_addr] <= item_i.table_value;
    end
    if (accept && is_wr_ok && item_i.mode == phnl_pkg::MODE_FINAL) begin
      final_mem[tidx_addr] <= item_i.table_value[9:0];
    end
    if (accept && is_key && item_i.key_char != 8'd0 && len_q < KLW'(MAX_KEY_LEN)) begin
      key_mem[len_q[KAW-1:0]] <= item_i.key_char;
    end
    disp_rd_q  <= disp_mem[disp_raddr];
    final_rd_q <= final_mem[faddr_q];
    key_rd_q   <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= NW'(1);
    end else if (cfg_we_i) begin
      num_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= phnl_pkg::S_IDLE;
      hash_q  <= phnl_pkg::FnvSeed;
      len_q   <= '0;
      kidx_q  <= '0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
      faddr_q <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      len_q   <= len_d;
      kidx_q  <= kidx_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      faddr_q <= faddr_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    hash_d  = hash_q;
    len_d   = len_q;
    kidx_d  = kidx_q;
    ovf_d   = ovf_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    faddr_d = faddr_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      phnl_pkg::S_IDLE: begin
        if (accept && is_key) begin
          // Fold and buffer a real character; a zero only ends the key.
          if (item_i.key_char != 8'd0) begin
            hash_d = fold_out;
            if (len_q < KLW'(MAX_KEY_LEN)) begin
              len_d = len_q + KLW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (is_end) begin
            state_d = phnl_pkg::S_CHECK;
          end
        end
      end
      phnl_pkg::S_CHECK: begin
        if (ovf_q || bad_num) begin
          done_d  = 1'b1;
          res_d   = '{file_index: 10'd0, lookup_error: 1'b1};
          hash_d  = phnl_pkg::FnvSeed;
          len_d   = '0;
          ovf_d   = 1'b0;
          state_d = phnl_pkg::S_IDLE;
        end else begin
          rem_d   = '0;
          cnt_d   = '0;
          phase_d = 1'b0;
          state_d = phnl_pkg::S_MOD;
        end
      end
      phnl_pkg::S_MOD: begin
        hash_d = {hash_q[30:0], 1'b0};
        if (trial >= {1'b0, num_q}) begin
          rem_d = NW'(trial - {1'b0, num_q});
        end else begin
          rem_d = trial[NW-1:0];
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          // Latch the final-table address so the read starts on the next cycle.
          faddr_d = AW'(rem_d);
          state_d = phase_q ? phnl_pkg::S_FIN_RD : phnl_pkg::S_DISP_RD;
        end
      end
      phnl_pkg::S_DISP_RD: begin
        faddr_d = disp_raddr;
        state_d = phnl_pkg::S_DISP_CHK;
      end
      phnl_pkg::S_DISP_CHK: begin
        if (disp_rd_q[31]) begin
          if (neg_j >= 32'(num_q)) begin
            done_d  = 1'b1;
            res_d   = '{file_index: 10'd0, lookup_error: 1'b1};
            hash_d  = phnl_pkg::FnvSeed;
            len_d   = '0;
            ovf_d   = 1'b0;
            state_d = phnl_pkg::S_IDLE;
          end else begin
            faddr_d = neg_j[AW-1:0];
            state_d = phnl_pkg::S_FIN_RD;
          end
        end else begin
          // Rehash the buffered key from the displacement seed.
          hash_d  = seed_d;
          kidx_d  = '0;
          rem_d   = '0;
          cnt_d   = '0;
          phase_d = 1'b1;
          state_d = (len_q == '0) ? phnl_pkg::S_MOD : phnl_pkg::S_KEY_RD;
        end
      end
      phnl_pkg::S_KEY_RD: begin
        state_d = phnl_pkg::S_KEY_FOLD;
      end
      phnl_pkg::S_KEY_FOLD: begin
        hash_d = fold_out;
        kidx_d = kidx_q + KLW'(1);
        state_d = (kidx_q + KLW'(1) == len_q) ? phnl_pkg::S_MOD : phnl_pkg::S_KEY_RD;
      end
      phnl_pkg::S_FIN_RD: begin
        state_d = phnl_pkg::S_FIN_OUT;
      end
      phnl_pkg::S_FIN_OUT: begin
        done_d  = 1'b1;
        res_d   = '{file_index: final_rd_q, lookup_error: 1'b0};
        hash_d  = phnl_pkg::FnvSeed;
        len_d   = '0;
        ovf_d   = 1'b0;
        state_d = phnl_pkg::S_IDLE;
      end
      default: state_d = phnl_pkg::S_IDLE;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A result only ever follows a cycle of lookup work.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without lookup work");

  // The end of a key always starts a lookup.
  a_end_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_end) |=> busy)
    else $error("key end did not start lookup");

  // The modulo leaves a remainder below the entry count.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == phnl_pkg::S_DISP_RD) |-> (rem_q < num_q))
    else $error("remainder out of range");

  // The key length never passes the buffer size.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= KLW'(MAX_KEY_LEN))
    else $error("key length overflow");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Name lookup testbench
// Streams keys and table writes into the perfect hash lookup, predicts each
// looked-up entry index or error flag, and compares every result strobe.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth  = 1024;
  localparam int unsigned KeyMax = 64;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  phnl_pkg::item_t   item = '0;
  logic              cfg_we = 1'b0;
  logic [phnl_pkg::NumW-1:0] cfg_wdata = '0;
  logic              done;
  phnl_pkg::result_t result;

  perfect_hash_name_lookup u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .item_i     (item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .done_o     (done),
    .result_o   (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: its own copy of both tables, the key and the modulus.
  logic [31:0]     disp_mem [Depth];
  logic [9:0]      final_mem [Depth];
  logic [7:0]      key_mem [KeyMax];
  int unsigned     key_len;
  logic [31:0]     key_hash;
  logic            key_ovf;
  logic [phnl_pkg::NumW-1:0] entries;

  phnl_pkg::item_t   pending_q [$];
  phnl_pkg::result_t lookups_q [$];
  int      errors = 0;
  int      items_sent = 0;

  function automatic logic [31:0] hash_step(logic [31:0] h, logic [7:0] c);
    return (h * 32'h0100_0193) ^ {{24{c[7]}}, c};
  endfunction

  function automatic phnl_pkg::result_t resolve_key();
    phnl_pkg::result_t r;
    logic [31:0] d;
    logic [31:0] h;
    logic [31:0] j;
    r = '0;
    if (key_ovf || entries == 0 || entries > Depth) begin
      r.lookup_error = 1'b1;
    end else begin
      d = disp_mem[10'(key_hash % entries)];
      if (d[31]) begin
        j = ~d;
        if (j >= entries) r.lookup_error = 1'b1;
        else r.file_index = final_mem[10'(j)];
      end else begin
        h = (d == 0) ? 32'h0100_0193 : d;
        for (int i = 0; i < key_len; i++) h = hash_step(h, key_mem[6'(i)]);
        r.file_index = final_mem[10'(h % entries)];
      end
    end
    key_len  = 0;
    key_hash = 32'h0100_0193;
    key_ovf  = 1'b0;
    return r;
  endfunction

  // Advance the predictor by one accepted transaction.
  function automatic void predict_item(phnl_pkg::item_t it);
    case (phnl_pkg::mode_e'(it.mode))
      phnl_pkg::MODE_DISP:  disp_mem[it.table_index] = it.table_value;
      phnl_pkg::MODE_FINAL: final_mem[it.table_index] = it.table_value[9:0];
      phnl_pkg::MODE_KEY: begin
        if (it.key_char == 0) begin
          lookups_q = {lookups_q, resolve_key()};
        end else begin
          key_hash = hash_step(key_hash, it.key_char);
          if (key_len < KeyMax) begin
            key_mem[6'(key_len)] = it.key_char;
            key_len++;
          end else begin
            key_ovf = 1'b1;
          end
          if (it.key_last) lookups_q = {lookups_q, resolve_key()};
        end
      end
      default: ;
    endcase
  endfunction

  // Acceptance seen at the last rising edge.
  logic busy_seen = 1'b0;

  // Driver: present queued transactions at the falling edge, with random gaps.
  int gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy_seen) begin
        // still waiting for acceptance; hold
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        item  <= pending_q.pop_front();
        start <= 1'b1;
        gap   <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                 ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Acceptance bookkeeping at the rising edge.
  always @(posedge clk) begin
    busy_seen <= 1'b0;
    if (rst_n && start && !busy) begin
      predict_item(item);
      busy_seen <= 1'b1;
    end
  end

  // Monitor: compare each result strobe with the oldest prediction.
  phnl_pkg::result_t want;
  always @(posedge clk) begin
    if (rst_n && done) begin
      if (lookups_q.size() == 0) begin
        $display("%0t: expected no result, got %h", $realtime, result);
        errors++;
      end else begin
        want = lookups_q.pop_front();
        if (result.file_index !== want.file_index ||
            result.lookup_error !== want.lookup_error) begin
          $display("%0t: expected idx %0d err %0d, got idx %0d err %0d", $realtime,
                   want.file_index, want.lookup_error,
                   result.file_index, result.lookup_error);
          errors++;
        end
      end
    end
  end

  // Stimulus helpers.
  task automatic push(phnl_pkg::mode_e m, int idx, logic [31:0] val, logic [7:0] ch,
                      bit last);
    phnl_pkg::item_t it;
    it.mode        = m;
    it.table_index = idx[9:0];
    it.table_value = val;
    it.key_char    = ch;
    it.key_last    = last;
    pending_q = {pending_q, it};
    items_sent++;
  endtask

  task automatic push_key(int len, bit by_zero);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      ch = 8'($urandom_range(1, 255));
      push(phnl_pkg::MODE_KEY, $urandom_range(0, 1023), $urandom, ch,
           (!by_zero && i == len - 1));
    end
    if (by_zero || len == 0)
      push(phnl_pkg::MODE_KEY, $urandom_range(0, 1023), $urandom, 8'h00,
           1'($urandom_range(0, 1)));
  endtask

  // Drain: wait for the queue to empty and every lookup to come back.
  task automatic drain();
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (start || busy || lookups_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_entries(int n);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n[phnl_pkg::NumW-1:0];
    entries    = n[phnl_pkg::NumW-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Fill every entry of both tables that the lookups can reach.
  task automatic load_tables(int n);
    int lim;
    lim = (n > Depth || n == 0) ? 0 : n;
    for (int i = 0; i < lim; i++) begin
      case ($urandom_range(0, 3))
        0: push(phnl_pkg::MODE_DISP, i, -$urandom_range(1, lim), '0, 1'b0);
        1: push(phnl_pkg::MODE_DISP, i, -$urandom_range(lim + 1, lim + 50), '0, 1'b0);
        2: push(phnl_pkg::MODE_DISP, i, 32'd0, '0, 1'b0);
        default: push(phnl_pkg::MODE_DISP, i, {1'b0, 31'($urandom)}, '0, 1'b0);
      endcase
      push(phnl_pkg::MODE_FINAL, i, $urandom, '0, 1'b0);
    end
  endtask

  int sizes [6] = '{1, 37, 0, 128, 1025, 2047};

  initial begin
    for (int i = 0; i < Depth; i++) begin
      disp_mem[i]  = '0;
      final_mem[i] = '0;
    end
    key_len  = 0;
    key_hash = 32'h0100_0193;
    key_ovf  = 1'b0;
    entries  = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: default modulus, extremes of the tables, terminator forms.
    load_tables(1);
    push(phnl_pkg::MODE_DISP, 1023, 32'h8000_0000, '0, 1'b0);
    push(phnl_pkg::MODE_FINAL, 1023, 32'hFFFF_FFFF, '0, 1'b0);
    push(phnl_pkg::MODE_NONE, 1023, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    push_key(1, 1'b0);
    push_key(5, 1'b1);
    push_key(0, 1'b1);
    push(phnl_pkg::MODE_KEY, 0, '0, 8'hFF, 1'b1);
    push(phnl_pkg::MODE_KEY, 0, '0, 8'h80, 1'b0);
    push(phnl_pkg::MODE_KEY, 0, '0, 8'h7F, 1'b1);
    push_key(KeyMax, 1'b0);
    push_key(KeyMax + 1, 1'b1);
    drain();

    // Phases through several moduli, extremes among them.
    foreach (sizes[s]) begin
      set_entries(sizes[s]);
      load_tables(sizes[s]);
      items_sent = 0;
      while (items_sent < 50) begin
        case ($urandom_range(0, 19))
          0: push(phnl_pkg::MODE_NONE, $urandom_range(0, 1023), $urandom,
                  8'($urandom), 1'($urandom));
          1: push_key(KeyMax + $urandom_range(0, 4), 1'($urandom_range(0, 1)));
          2: push(phnl_pkg::MODE_FINAL, $urandom_range(0, sizes[s] > 0 && sizes[s] < Depth
                  ? sizes[s] - 1 : 1023), $urandom, '0, 1'b0);
          default: push_key($urandom_range(0, 8), 1'($urandom_range(0, 1)));
        endcase
      end
      drain();
    end
    set_entries(1);
    push_key(3, 1'b0);
    drain();
    if (errors == 0) $display("perfect_hash_name_lookup: match");
    else $display("perfect_hash_name_lookup: mismatch");
    $finish;
  end

  initial begin
    #40ms;
    $display("perfect_hash_name_lookup: mismatch");
    $finish;
  end
endmodule

[perfect_hash_name_lookup.f]
rtl/core/phnl_pkg.sv
rtl/core/perfect_hash_name_lookup.sv
tb/tb.sv
